// ===== hw/rtl/fcst_pkg.sv =====
`default_nettype none
package fcst_pkg;

  localparam int unsigned SLOT_W  = 10;
  localparam int unsigned STATE_W = 4;
  localparam int unsigned FLAGS_W = 6;
  localparam int unsigned ENTRY_W = STATE_W + FLAGS_W;

  // seen_flags bit positions
  localparam int unsigned FL_FIN_OUT = 0;
  localparam int unsigned FL_FIN_IN  = 1;
  localparam int unsigned FL_SYN_OUT = 2;
  localparam int unsigned FL_SYN_IN  = 3;
  localparam int unsigned FL_OUT     = 4;
  localparam int unsigned FL_RST     = 5;

  // ICMP types that never open a flow
  localparam logic [7:0] ICMP_DEST_UNREACH   = 8'd3;
  localparam logic [7:0] ICMP_SOURCE_QUENCH  = 8'd4;
  localparam logic [7:0] ICMP_TIME_EXCEEDED  = 8'd11;
  localparam logic [7:0] ICMP_PARAM_PROBLEM  = 8'd12;
  localparam logic [7:0] ICMP_CONVERSION_ERR = 8'd31;

  typedef enum logic [2:0] {
    OC_UPDATED    = 3'd0,
    OC_CREATED    = 3'd1,
    OC_FILTERED   = 3'd2,
    OC_REFUSED    = 3'd3,
    OC_NOTFLOW    = 3'd4,
    OC_ERRAPPLIED = 3'd5,
    OC_ERRIGNORED = 3'd6
  } outcome_e;

  typedef enum logic [3:0] {
    CS_NONE      = 4'd0,
    CS_NEW       = 4'd1,
    CS_ANYSTART  = 4'd2,
    CS_CONN      = 4'd3,
    CS_ESTAB     = 4'd4,
    CS_HALFCLOSE = 4'd5,
    CS_CLOSE     = 4'd6,
    CS_RESET     = 4'd7,
    CS_UDPSHORT  = 4'd8,
    CS_UDPLONG   = 4'd9,
    CS_ICMPERR   = 4'd10
  } conn_state_e;

  typedef enum logic [1:0] {
    PROTO_TCP   = 2'd0,
    PROTO_UDP   = 2'd1,
    PROTO_ICMP  = 2'd2,
    PROTO_OTHER = 2'd3
  } proto_e;

  typedef enum logic [1:0] {
    CFG_TCP_ANY_START   = 2'd0,
    CFG_ICMP_ERR_BYPASS = 2'd1,
    CFG_DROP_IPV4       = 2'd2,
    CFG_DROP_IPV6       = 2'd3
  } cfg_index_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REDUCE,
    S_READ,
    S_UPDATE
  } fsm_state_e;

  typedef struct packed {
    logic              kind;
    logic [SLOT_W-1:0] flow_slot;
    logic              hit;
    logic [1:0]        proto_class;
    logic              direction;
    logic              syn_flag;
    logic              ack_flag;
    logic              fin_flag;
    logic              rst_flag;
    logic              is_ipv6;
    logic              ports_zero;
    logic [7:0]        icmp_type;
  } item_t;

  typedef struct packed {
    logic [2:0]         outcome;
    logic [SLOT_W-1:0]  slot_out;
    logic [STATE_W-1:0] state_out;
  } result_t;

  typedef struct packed {
    logic tcp_any_start;
    logic icmp_err_bypass;
    logic drop_ipv4;
    logic drop_ipv6;
  } cfg_t;

  typedef struct packed {
    logic load;   // capture a new item
    logic step;   // one remainder step
    logic rd_en;  // read the table entry
    logic upd;    // write back and present the result
  } cmd_t;

  typedef struct packed {
    logic need_red;  // slot needs a remainder pass
    logic red_last;  // last remainder step this cycle
  } status_t;

  function automatic logic icmp_non_flow(logic [7:0] t);
    return (t == ICMP_DEST_UNREACH) || (t == ICMP_SOURCE_QUENCH) ||
           (t == ICMP_TIME_EXCEEDED) || (t == ICMP_PARAM_PROBLEM) ||
           (t == ICMP_CONVERSION_ERR);
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/flow_connection_state_tracker.sv =====
// An accepted word is loaded, reduced by the slot remainder stage when
//   FLOW_SLOTS is below 1024 and not a power of two, read, and written back
//   with its result registered. A new word can be accepted in the write-back
//   cycle; the table is read in one cycle and written back in the next.
// Reset clears control and config registers; table contents are not cleared.
// The result is shown for exactly one cycle; the receiver cannot stall.
`default_nettype none
module flow_connection_state_tracker
  import fcst_pkg::*;
#(
  parameter int unsigned FLOW_SLOTS = 1024
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire item_t      item_i,
  output logic            done_o,
  output result_t         result_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic       cfg_data_i
);

  cfg_t    cfg_q;
  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_TCP_ANY_START:   cfg_q.tcp_any_start   <= cfg_data_i;
        CFG_ICMP_ERR_BYPASS: cfg_q.icmp_err_bypass <= cfg_data_i;
        CFG_DROP_IPV4:       cfg_q.drop_ipv4       <= cfg_data_i;
        CFG_DROP_IPV6:       cfg_q.drop_ipv6       <= cfg_data_i;
        default:             cfg_q                 <= cfg_q;
      endcase
    end
  end

  fcst_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  fcst_datapath #(
    .FLOW_SLOTS (FLOW_SLOTS)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .cfg_i    (cfg_q),
    .cmd_i    (cmd),
    .status_o (status),
    .result_o (result_o),
    .done_o   (done_o)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/fcst_ctrl.sv =====
`default_nettype none
module fcst_ctrl
  import fcst_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start,
  output logic         busy,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  fsm_state_e state_q, state_d;
  logic       accept;

  assign accept = start && ((state_q == S_IDLE) || (state_q == S_UPDATE));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE, S_UPDATE: begin
        if (accept) begin
          state_d = status_i.need_red ? S_REDUCE : S_READ;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_REDUCE: begin
        if (status_i.red_last) begin
          state_d = S_READ;
        end
      end
      S_READ:   state_d = S_UPDATE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy  = 1'b0;
    cmd_o.load = accept;
    unique case (state_q)
      S_IDLE:   busy = 1'b0;
      S_REDUCE: begin
        busy       = 1'b1;
        cmd_o.step = 1'b1;
      end
      S_READ: begin
        busy        = 1'b1;
        cmd_o.rd_en = 1'b1;
      end
      S_UPDATE: cmd_o.upd = 1'b1;
      default:  busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_read_then_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ |=> state_q == S_UPDATE)
    else $error("read not followed by update");

  a_busy_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy without a start");

  a_reduce_only_when_needed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_REDUCE |-> status_i.need_red)
    else $error("remainder pass on a direct-indexed table");

endmodule
`default_nettype wire

// ===== hw/rtl/fcst_datapath.sv =====
`default_nettype none
module fcst_datapath
  import fcst_pkg::*;
#(
  parameter int unsigned FLOW_SLOTS = 1024
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire item_t item_i,
  input  wire cfg_t  cfg_i,
  input  wire cmd_t  cmd_i,
  output status_t    status_o,
  output result_t    result_o,
  output logic       done_o
);

  localparam int unsigned AW = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
  localparam bit NEED_MOD = (FLOW_SLOTS < (1 << SLOT_W)) &&
                            ((FLOW_SLOTS & (FLOW_SLOTS - 1)) != 0);

  item_t           item_q;
  logic [AW-1:0]   idx;
  logic [ENTRY_W-1:0] entry_mem [FLOW_SLOTS];
  logic [ENTRY_W-1:0] rdata_q;
  logic [STATE_W-1:0] rd_state;
  logic [FLAGS_W-1:0] rd_flags;

  result_t result_q;
  logic    done_q;

  logic [2:0]         oc;
  logic [STATE_W-1:0] st_res;
  logic [STATE_W-1:0] st;
  logic [FLAGS_W-1:0] fl;
  logic               wr_en;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
  end

  // slot index: remainder by FLOW_SLOTS through a reciprocal multiply;
  // first step registers the quotient, second the remainder
  if (NEED_MOD) begin : g_mod
    localparam int unsigned RK = SLOT_W + AW;
    localparam int unsigned MW = SLOT_W + 1;
    localparam int unsigned QW = MW - AW;
    localparam logic [MW-1:0] RECIP =
      MW'(((64'd1 << RK) + 64'(FLOW_SLOTS) - 64'd1) / 64'(FLOW_SLOTS));
    localparam logic [SLOT_W-1:0] SLOTS_C = SLOT_W'(FLOW_SLOTS);
    logic [SLOT_W+MW-1:0] prod;
    logic [QW-1:0]        quo_q;
    logic [QW+SLOT_W-1:0] back;
    logic [SLOT_W-1:0]    rem;
    logic [AW-1:0]        rem_q;
    logic                 ph_q;

    assign prod = {{MW{1'b0}}, item_q.flow_slot} * {{SLOT_W{1'b0}}, RECIP};
    assign back = {{SLOT_W{1'b0}}, quo_q} * {{QW{1'b0}}, SLOTS_C};
    assign rem  = item_q.flow_slot - back[SLOT_W-1:0];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ph_q <= 1'b0;
      end else if (cmd_i.load) begin
        ph_q <= 1'b0;
      end else if (cmd_i.step) begin
        ph_q <= 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.step) begin
        quo_q <= prod[SLOT_W+MW-1:RK];
        rem_q <= rem[AW-1:0];
      end
    end

    assign idx               = rem_q;
    assign status_o.need_red = 1'b1;
    assign status_o.red_last = ph_q;
  end else begin : g_direct
    assign idx               = AW'(item_q.flow_slot);
    assign status_o.need_red = 1'b0;
    assign status_o.red_last = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd && wr_en) begin
      entry_mem[idx] <= {st, fl};
    end
    if (cmd_i.rd_en) begin
      rdata_q <= entry_mem[idx];
    end
  end

  assign rd_state = rdata_q[ENTRY_W-1:FLAGS_W];
  assign rd_flags = rdata_q[FLAGS_W-1:0];

  always_comb begin
    logic [STATE_W-1:0] ns;
    logic               filtered;
    oc       = OC_UPDATED;
    st_res   = CS_NONE;
    st       = rd_state;
    fl       = rd_flags;
    wr_en    = 1'b0;
    ns       = CS_NONE;
    filtered = (item_q.is_ipv6 && cfg_i.drop_ipv6) ||
               (!item_q.is_ipv6 && cfg_i.drop_ipv4) ||
               (item_q.ports_zero && ((item_q.proto_class == PROTO_TCP) ||
                                      (item_q.proto_class == PROTO_UDP)));
    if (item_q.kind) begin
      if (cfg_i.icmp_err_bypass || !item_q.hit) begin
        oc     = OC_ERRIGNORED;
        st_res = item_q.hit ? rd_state : CS_NONE;
      end else begin
        oc     = OC_ERRAPPLIED;
        st     = CS_ICMPERR;
        st_res = CS_ICMPERR;
        wr_en  = 1'b1;
      end
    end else if (filtered) begin
      oc = OC_FILTERED;
    end else begin
      if (!item_q.hit) begin
        case (item_q.proto_class)
          PROTO_TCP: begin
            if (cfg_i.tcp_any_start) begin
              ns = CS_ANYSTART;
            end else if (item_q.syn_flag && !item_q.ack_flag) begin
              ns = CS_NEW;
            end else begin
              oc = OC_REFUSED;
            end
          end
          PROTO_UDP:  ns = CS_UDPSHORT;
          PROTO_ICMP: begin
            if (icmp_non_flow(item_q.icmp_type)) begin
              oc = OC_NOTFLOW;
            end
          end
          default:    ns = CS_NONE;
        endcase
        if (oc == OC_UPDATED) begin
          oc = OC_CREATED;
          st = ns;
          fl = '0;
          if ((item_q.proto_class == PROTO_UDP) && !item_q.direction) begin
            fl[FL_OUT] = 1'b1;
          end
        end
      end
      if ((oc == OC_UPDATED) || (oc == OC_CREATED)) begin
        if (item_q.proto_class == PROTO_TCP) begin
          if (item_q.fin_flag) begin
            if (item_q.direction) fl[FL_FIN_IN] = 1'b1;
            else                  fl[FL_FIN_OUT] = 1'b1;
            st = (fl[FL_FIN_IN] && fl[FL_FIN_OUT]) ? CS_CLOSE : CS_HALFCLOSE;
          end
          if (item_q.syn_flag) begin
            if (item_q.direction) fl[FL_SYN_IN] = 1'b1;
            else                  fl[FL_SYN_OUT] = 1'b1;
            if (fl[FL_SYN_IN] && fl[FL_SYN_OUT]) begin
              if (item_q.ack_flag) st = CS_ESTAB;
            end else begin
              st = CS_CONN;
            end
          end
          if (item_q.rst_flag) begin
            fl[FL_RST] = 1'b1;
            st         = CS_RESET;
          end
        end else if ((item_q.proto_class == PROTO_UDP) && !item_q.direction) begin
          // an outbound packet promotes the flow once FL_OUT is set, also the one that opened it
          if (!fl[FL_OUT]) fl[FL_OUT] = 1'b1;
          else             st = CS_UDPLONG;
        end
        wr_en  = 1'b1;
        st_res = st;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd) begin
      result_q.outcome   <= oc;
      result_q.slot_out  <= item_q.flow_slot;
      result_q.state_out <= st_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.upd;
    end
  end

  assign result_o = result_q;
  assign done_o   = done_q;

  a_done_after_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(cmd_i.upd))
    else $error("result strobe without an update cycle");

  a_no_state_on_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && ((result_q.outcome == OC_FILTERED) || (result_q.outcome == OC_REFUSED) ||
               (result_q.outcome == OC_NOTFLOW)) |-> result_q.state_out == CS_NONE)
    else $error("rejected word reports a state");

  a_error_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && (result_q.outcome == OC_ERRAPPLIED) |-> result_q.state_out == CS_ICMPERR)
    else $error("applied ICMP error without error state");

endmodule
`default_nettype wire
